### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each helper checks on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dsdc_pkg.sv
// ----------------------------------------------------------------------------
// dsdc_pkg
// Types, constants and calendar tables for the date / serial day converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsdc_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int unsigned SER_W  = 22;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned REM_W  = 22;
  localparam int unsigned ACC_W  = 23;
  localparam int unsigned DOY_W  = 9;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STEP_W = 3;

  localparam logic [SER_W-1:0]  SERIAL_MIN = SER_W'(620549);
  localparam logic [SER_W-1:0]  SERIAL_OFS = SER_W'(2);
  localparam logic [15:0]       BASE_YEAR  = 16'd1700;
  localparam logic [MON_W-1:0]  MONTH_JAN  = MON_W'(1);
  localparam logic [MON_W-1:0]  MONTH_FEB  = MON_W'(2);
  localparam logic [MON_W-1:0]  MONTH_DEC  = MON_W'(12);
  localparam logic [DOY_W-1:0]  DAY_LAST   = DOY_W'(31);

  localparam logic ACT_TO_SERIAL = 1'b0;
  localparam logic ACT_TO_DATE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Chunk sizes: 400, 100, 4 and 1 years
  typedef enum logic [1:0] {
    PH_400,
    PH_100,
    PH_4,
    PH_1
  } phase_t;

  // Index of the first (largest) shift tried in each chunk phase.
  function automatic logic [STEP_W-1:0] phase_last(phase_t ph);
    logic [STEP_W-1:0] k;
    unique case (ph)
      PH_400:  k = STEP_W'(5);
      PH_100:  k = STEP_W'(1);
      PH_4:    k = STEP_W'(4);
      PH_1:    k = STEP_W'(1);
      default: k = '0;
    endcase
    return k;
  endfunction

  // Days in one chunk of each size.
  function automatic logic [ACC_W-1:0] chunk_days(phase_t ph);
    logic [ACC_W-1:0] v;
    unique case (ph)
      PH_400:  v = ACC_W'(146097);
      PH_100:  v = ACC_W'(36524);
      PH_4:    v = ACC_W'(1461);
      PH_1:    v = ACC_W'(365);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] chunk_years(phase_t ph);
    logic [ACC_W-1:0] v;
    unique case (ph)
      PH_400:  v = ACC_W'(400);
      PH_100:  v = ACC_W'(100);
      PH_4:    v = ACC_W'(4);
      PH_1:    v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Divisor, shifted to the first step: years when going to serial, days otherwise.
  function automatic logic [ACC_W-1:0] div_init(logic act, phase_t ph);
    logic [ACC_W-1:0] v;
    v = (act == ACT_TO_DATE) ? chunk_days(ph) : chunk_years(ph);
    return v << phase_last(ph);
  endfunction

  // Weight accumulated per chunk taken: days when going to serial, years otherwise.
  function automatic logic [ACC_W-1:0] wt_init(logic act, phase_t ph);
    logic [ACC_W-1:0] v;
    v = (act == ACT_TO_DATE) ? chunk_years(ph) : chunk_days(ph);
    return v << phase_last(ph);
  endfunction

  function automatic logic [DOY_W-1:0] days_before_month(logic [MON_W-1:0] m);
    logic [DOY_W-1:0] v;
    unique case (m)
      4'd1:    v = DOY_W'(0);
      4'd2:    v = DOY_W'(31);
      4'd3:    v = DOY_W'(59);
      4'd4:    v = DOY_W'(90);
      4'd5:    v = DOY_W'(120);
      4'd6:    v = DOY_W'(151);
      4'd7:    v = DOY_W'(181);
      4'd8:    v = DOY_W'(212);
      4'd9:    v = DOY_W'(243);
      4'd10:   v = DOY_W'(273);
      4'd11:   v = DOY_W'(304);
      4'd12:   v = DOY_W'(334);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [DOY_W-1:0] month_len(logic [MON_W-1:0] m, logic leap);
    logic [DOY_W-1:0] v;
    unique case (m)
      4'd2:                    v = leap ? DOY_W'(29) : DOY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: v = DOY_W'(30);
      default:                 v = DOY_W'(31);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/date_serial_day_converter.sv
// Sequence from accept to strobe: date to serial runs the year split (ST_DIV), then
//   ST_FIN; serial to date runs the year split, ST_YEAR and the month walk (ST_MONTH).
// Throughput: busy stays high until the strobe cycle, so a new item can be
//   taken the cycle after it; one shared compare/subtract unit sets the pace.
// The strobe is one cycle wide and cannot be stalled.
// Reset (rst_n low, synchronous) returns the sequencer to idle.
`default_nettype none

module date_serial_day_converter #(
  parameter int unsigned MAX_YEAR = dsdc_pkg::MAX_YEAR_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_action,
  input  wire logic [dsdc_pkg::YEAR_W-1:0]  in_year,
  input  wire logic [dsdc_pkg::MON_W-1:0]   in_month,
  input  wire logic [dsdc_pkg::DAY_W-1:0]   in_day,
  input  wire logic [dsdc_pkg::SER_W-1:0]   in_serial,
  output logic                              out_valid,
  output logic [dsdc_pkg::SER_W-1:0]        out_serial,
  output logic [dsdc_pkg::YEAR_W-1:0]       out_year,
  output logic [dsdc_pkg::MON_W-1:0]        out_month,
  output logic [dsdc_pkg::DAY_W-1:0]        out_day
);
  import dsdc_pkg::*;
  `include "assert_macros.svh"

  localparam logic [15:0]      MaxYear16  = 16'(MAX_YEAR);
  localparam logic [ACC_W-1:0] MaxYearAcc = ACC_W'(MAX_YEAR);

  state_t              state_r,  state_nxt;
  phase_t              phase_r,  phase_nxt;
  logic                act_r,    act_nxt;
  logic [REM_W-1:0]    rem_r,    rem_nxt;
  logic [ACC_W-1:0]    div_r,    div_nxt;
  logic [ACC_W-1:0]    wt_r,     wt_nxt;
  logic [ACC_W-1:0]    acc_r,    acc_nxt;
  logic [CNT_W-1:0]    cnt_r,    cnt_nxt;
  logic [STEP_W-1:0]   k_r,      k_nxt;
  logic [1:0]          b_r,      b_nxt;
  logic [4:0]          c_r,      c_nxt;
  logic                leap_r,   leap_nxt;
  logic [SER_W-1:0]    ser_r,    ser_nxt;
  logic [YEAR_W-1:0]   yr_r,     yr_nxt;
  logic [MON_W-1:0]    mon_r,    mon_nxt;
  logic [DOY_W-1:0]    doy_r,    doy_nxt;

  logic [15:0]         year_c;
  logic [SER_W-1:0]    ser_c;
  logic                ge;
  phase_t              phase_next;
  logic [ACC_W-1:0]    sum;
  logic [ACC_W-1:0]    year_full;
  logic [DOY_W-1:0]    mlen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    act_r   <= act_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    wt_r    <= wt_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    leap_r  <= leap_nxt;
    ser_r   <= ser_nxt;
    yr_r    <= yr_nxt;
    mon_r   <= mon_nxt;
    doy_r   <= doy_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    act_nxt   = act_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    wt_nxt    = wt_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    leap_nxt  = leap_r;
    ser_nxt   = ser_r;
    yr_nxt    = yr_r;
    mon_nxt   = mon_r;
    doy_nxt   = doy_r;

    // clamp the year and month into the supported range and the serial to its minimum
    year_c = {2'b00, in_year};
    if (year_c < BASE_YEAR) begin
      year_c = BASE_YEAR;
    end
    if (year_c > MaxYear16) begin
      year_c = MaxYear16;
    end
    ser_c = (in_serial < SERIAL_MIN) ? SERIAL_MIN : in_serial;

    ge         = {1'b0, rem_r} >= div_r;
    phase_next = phase_r;
    unique case (phase_r)
      PH_400:  phase_next = PH_100;
      PH_100:  phase_next = PH_4;
      PH_4:    phase_next = PH_1;
      PH_1:    phase_next = PH_1;
      default: phase_next = PH_400;
    endcase

    sum = acc_r + ACC_W'(days_before_month(mon_r))
        + ACC_W'(leap_r && (mon_r > MONTH_FEB)) + ACC_W'(doy_r) + ACC_W'(1);
    year_full = acc_r + ACC_W'(1);
    mlen      = month_len(mon_r, leap_r);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          phase_nxt = PH_400;
          div_nxt   = div_init(in_action, PH_400);
          wt_nxt    = wt_init(in_action, PH_400);
          k_nxt     = phase_last(PH_400);
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
          if (in_action == ACT_TO_DATE) begin
            ser_nxt = ser_c;
            rem_nxt = ser_c - SERIAL_OFS;
          end else begin
            yr_nxt  = year_c[YEAR_W-1:0];
            rem_nxt = REM_W'(year_c) - REM_W'(1);
            mon_nxt = (in_month < MONTH_JAN) ? MONTH_JAN :
                      (in_month > MONTH_DEC) ? MONTH_DEC : in_month;
            doy_nxt = DOY_W'(in_day);
          end
        end
      end
      ST_DIV: begin
        // one restoring step: take the shifted chunk if it fits
        if (ge) begin
          rem_nxt = rem_r - div_r[REM_W-1:0];
          acc_nxt = acc_r + wt_r;
        end
        cnt_nxt = {cnt_r[CNT_W-2:0], ge};
        div_nxt = div_r >> 1;
        wt_nxt  = wt_r >> 1;
        k_nxt   = k_r - STEP_W'(1);
        if (k_r == '0) begin
          unique case (phase_r)
            PH_100:  b_nxt = cnt_nxt[1:0];
            PH_4:    c_nxt = cnt_nxt[4:0];
            PH_1:    leap_nxt = (cnt_nxt[1:0] == 2'd3) && ((c_r != 5'd24) || (b_r == 2'd3));
            default: ;
          endcase
          if (phase_r == PH_1) begin
            state_nxt = (act_r == ACT_TO_DATE) ? ST_YEAR : ST_FIN;
          end else begin
            phase_nxt = phase_next;
            div_nxt   = div_init(act_r, phase_next);
            wt_nxt    = wt_init(act_r, phase_next);
            k_nxt     = phase_last(phase_next);
            cnt_nxt   = '0;
          end
        end
      end
      ST_FIN: begin
        ser_nxt   = sum[SER_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_YEAR: begin
        if (year_full > MaxYearAcc) begin
          // past the last year: pin to its final day
          yr_nxt    = YEAR_W'(MAX_YEAR);
          mon_nxt   = MONTH_DEC;
          doy_nxt   = DAY_LAST;
          state_nxt = ST_DONE;
        end else begin
          yr_nxt    = year_full[YEAR_W-1:0];
          mon_nxt   = MONTH_JAN;
          doy_nxt   = DOY_W'(rem_r) + DOY_W'(1);
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if ((mon_r < MONTH_DEC) && (doy_r > mlen)) begin
          doy_nxt = doy_r - mlen;
          mon_nxt = mon_r + MON_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_DONE);
  assign out_serial = ser_r;
  assign out_year   = yr_r;
  assign out_month  = mon_r;
  assign out_day    = doy_r[DAY_W-1:0];

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `ASSERT_NEXT(a_strobe_once, out_valid, !out_valid && !busy, "result strobe not single")
  `ASSERT_SAME(a_month_walk, state_r == ST_MONTH,
               (mon_r >= MONTH_JAN) && (mon_r <= MONTH_DEC) && (doy_r != '0),
               "month walk out of range")
  `ASSERT_SAME(a_date_day, out_valid && act_r == ACT_TO_DATE,
               (out_day != '0) && (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC),
               "converted date out of range")

endmodule

`default_nettype wire
